>>> src/tun_pkg.sv
package tun_pkg;

  // Number of vector components handled side by side.
  localparam int LANES = 3;

  // Width of each normal component on the result ports.
  localparam int OUT_W = 16;

endpackage

>>> src/triangle_unit_normal.sv
// Unit normal of a triangle: cross product, pipelined square root and divide, Q1.FRAC_BITS out.
// The root and quotient pipelines resolve one bit per stage.
// A new word is taken every cycle; busy_o stays low.
// The receiver cannot stall, so every result appears on its strobe exactly once.
// Reset clears only the valid bits of the pipeline; data registers are not reset.
module triangle_unit_normal #(
  parameter int COORD_WIDTH = 16,
  parameter int FRAC_BITS   = 14
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic                          mode_i,
  input  logic signed [COORD_WIDTH-1:0] ax_i,
  input  logic signed [COORD_WIDTH-1:0] ay_i,
  input  logic signed [COORD_WIDTH-1:0] az_i,
  input  logic signed [COORD_WIDTH-1:0] bx_i,
  input  logic signed [COORD_WIDTH-1:0] by_i,
  input  logic signed [COORD_WIDTH-1:0] bz_i,
  input  logic signed [COORD_WIDTH-1:0] cx_i,
  input  logic signed [COORD_WIDTH-1:0] cy_i,
  input  logic signed [COORD_WIDTH-1:0] cz_i,
  output logic                          valid_o,
  output logic signed [tun_pkg::OUT_W-1:0] nx_o,
  output logic signed [tun_pkg::OUT_W-1:0] ny_o,
  output logic signed [tun_pkg::OUT_W-1:0] nz_o,
  output logic                          degenerate_o
);
  import tun_pkg::*;

  localparam int MW  = 2 * COORD_WIDTH + 2;
  localparam int SW  = 2 * MW + 2;
  localparam int RW  = MW + 1;
  localparam int QW  = FRAC_BITS + 1;
  localparam int SDW = LANES * MW + LANES + 1;
  localparam int DDW = LANES + 1;

  logic signed [COORD_WIDTH-1:0] a_vec [LANES];
  logic signed [COORD_WIDTH-1:0] b_vec [LANES];
  logic signed [COORD_WIDTH-1:0] c_vec [LANES];

  logic             fr_valid;
  logic [SW-1:0]    fr_sum;
  logic [MW-1:0]    fr_mag [LANES];
  logic [LANES-1:0] fr_neg;
  logic [SDW-1:0]   sq_side_in;

  logic             sq_valid;
  logic [RW-1:0]    sq_root;
  logic [SDW-1:0]   sq_side;
  logic [MW-1:0]    sq_mag [LANES];

  logic             dv_valid;
  logic [QW-1:0]    dv_quo [LANES];
  logic [DDW-1:0]   dv_side;

  logic             valid_q;
  logic [OUT_W-1:0] comp_d [LANES];
  logic [OUT_W-1:0] comp_q [LANES];
  logic             degen_q;

  // Every cycle can take a new word.
  assign busy_o = 1'b0;

  assign a_vec = '{ax_i, ay_i, az_i};
  assign b_vec = '{bx_i, by_i, bz_i};
  assign c_vec = '{cx_i, cy_i, cz_i};

  tun_front #(
    .CW (COORD_WIDTH),
    .MW (MW),
    .SW (SW)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start_i),
    .mode_i  (mode_i),
    .a_i     (a_vec),
    .b_i     (b_vec),
    .c_i     (c_vec),
    .valid_o (fr_valid),
    .sum_o   (fr_sum),
    .mag_o   (fr_mag),
    .neg_o   (fr_neg)
  );

  // Magnitudes, signs and the zero-length flag ride along with the root.
  assign sq_side_in = {fr_mag[2], fr_mag[1], fr_mag[0], fr_neg, (fr_sum == '0)};

  tun_sqrt #(
    .SW (SW),
    .RW (RW),
    .DW (SDW)
  ) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (fr_valid),
    .rad_i   (fr_sum),
    .side_i  (sq_side_in),
    .valid_o (sq_valid),
    .root_o  (sq_root),
    .side_o  (sq_side)
  );

  for (genvar l = 0; l < LANES; l++) begin : g_unpack
    assign sq_mag[l] = sq_side[DDW + l*MW +: MW];
  end

  tun_div #(
    .MW        (MW),
    .RW        (RW),
    .FRAC_BITS (FRAC_BITS),
    .DW        (DDW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (sq_valid),
    .den_i   (sq_root),
    .num_i   (sq_mag),
    .side_i  (sq_side[DDW-1:0]),
    .valid_o (dv_valid),
    .quo_o   (dv_quo),
    .side_o  (dv_side)
  );

  // Clamp to one, restore the sign and force zero for a degenerate triangle.
  // The negation is taken wide enough that it wraps correctly to the output width.
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      logic [QW-1:0] mag;
      mag = (dv_quo[l] > (QW'(1) << FRAC_BITS)) ? (QW'(1) << FRAC_BITS) : dv_quo[l];
      if (dv_side[0]) begin
        comp_d[l] = '0;
      end else if (dv_side[1 + l]) begin
        comp_d[l] = OUT_W'(-(QW + OUT_W)'(mag));
      end else begin
        comp_d[l] = OUT_W'(mag);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= dv_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    comp_q  <= comp_d;
    degen_q <= dv_side[0];
  end

  assign valid_o      = valid_q;
  assign nx_o         = comp_q[0];
  assign ny_o         = comp_q[1];
  assign nz_o         = comp_q[2];
  assign degenerate_o = degen_q;

endmodule

>>> src/tun_front.sv
module tun_front #(
  parameter int CW = 16,
  parameter int MW = 2 * CW + 2,
  parameter int SW = 2 * MW + 2
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  logic                 mode_i,
  input  logic signed [CW-1:0] a_i [tun_pkg::LANES],
  input  logic signed [CW-1:0] b_i [tun_pkg::LANES],
  input  logic signed [CW-1:0] c_i [tun_pkg::LANES],
  output logic                 valid_o,
  output logic [SW-1:0]        sum_o,
  output logic [MW-1:0]        mag_o [tun_pkg::LANES],
  output logic [tun_pkg::LANES-1:0] neg_o
);
  import tun_pkg::*;

  localparam int EW    = CW + 1;
  localparam int PW    = 2 * EW;
  localparam int NW    = PW + 1;
  localparam int DEPTH = 6;

  logic [DEPTH-1:0]        valid_q;
  logic signed [EW-1:0]    e1_q [LANES];
  logic signed [EW-1:0]    e2_q [LANES];
  logic signed [PW-1:0]    prod_q [2 * LANES];
  logic signed [NW-1:0]    n_q [LANES];
  logic [MW-1:0]           mag_q [LANES];
  logic [MW-1:0]           mag2_q [LANES];
  logic [MW-1:0]           mag3_q [LANES];
  logic [LANES-1:0]        neg_q;
  logic [LANES-1:0]        neg2_q;
  logic [LANES-1:0]        neg3_q;
  logic [2*MW-1:0]         sq_q [LANES];
  logic [SW-1:0]           sum_q;

  // Valid bits travel alongside the data through every stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[DEPTH-2:0], valid_i};
    end
  end

  // Stage one: edge vectors, either given directly or as differences of points.
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < LANES; i++) begin
      if (mode_i) begin
        e1_q[i] <= EW'(a_i[i]);
        e2_q[i] <= EW'(b_i[i]);
      end else begin
        e1_q[i] <= EW'(b_i[i]) - EW'(a_i[i]);
        e2_q[i] <= EW'(c_i[i]) - EW'(a_i[i]);
      end
    end
  end

  // Stage two: the six partial products of the cross product.
  always_ff @(posedge clk_i) begin
    prod_q[0] <= e1_q[1] * e2_q[2];
    prod_q[1] <= e2_q[1] * e1_q[2];
    prod_q[2] <= e1_q[2] * e2_q[0];
    prod_q[3] <= e2_q[2] * e1_q[0];
    prod_q[4] <= e1_q[0] * e2_q[1];
    prod_q[5] <= e2_q[0] * e1_q[1];
  end

  // Stage three: cross product components, exact.
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < LANES; i++) begin
      n_q[i] <= NW'(prod_q[2*i]) - NW'(prod_q[2*i+1]);
    end
  end

  // Stage four: sign and magnitude of each component.
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < LANES; i++) begin
      neg_q[i] <= n_q[i][NW-1];
      mag_q[i] <= n_q[i][NW-1] ? MW'(-n_q[i]) : MW'(n_q[i]);
    end
  end

  // Stage five: squares of the magnitudes.
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < LANES; i++) begin
      sq_q[i]   <= mag_q[i] * mag_q[i];
      mag2_q[i] <= mag_q[i];
    end
    neg2_q <= neg_q;
  end

  // Stage six: sum of squares.
  always_ff @(posedge clk_i) begin
    sum_q <= SW'(sq_q[0]) + SW'(sq_q[1]) + SW'(sq_q[2]);
    for (int i = 0; i < LANES; i++) begin
      mag3_q[i] <= mag2_q[i];
    end
    neg3_q <= neg2_q;
  end

  assign valid_o = valid_q[DEPTH-1];
  assign sum_o   = sum_q;
  assign mag_o   = mag3_q;
  assign neg_o   = neg3_q;

endmodule

>>> src/tun_sqrt.sv
module tun_sqrt #(
  parameter int SW = 70,
  parameter int RW = 35,
  parameter int DW = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  logic [SW-1:0] rad_i,
  input  logic [DW-1:0] side_i,
  output logic          valid_o,
  output logic [RW-1:0] root_o,
  output logic [DW-1:0] side_o
);

  localparam int TW = SW + 1;

  logic [RW-1:0] valid_q;
  logic [TW-1:0] rem_q  [RW];
  logic [RW-1:0] root_q [RW];
  logic [DW-1:0] side_q [RW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[RW-2:0], valid_i};
    end
  end

  // One root bit per stage, most significant first; the remainder holds rad - root^2.
  for (genvar k = 0; k < RW; k++) begin : g_stage
    localparam int B = RW - 1 - k;
    logic [TW-1:0] rem_in;
    logic [RW-1:0] root_in;
    logic [DW-1:0] side_in;
    logic [TW-1:0] trial;

    if (k == 0) begin : g_first
      assign rem_in  = TW'(rad_i);
      assign root_in = '0;
      assign side_in = side_i;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign side_in = side_q[k-1];
    end

    // Growth of the square when bit B is set: 2*root*2^B + 2^(2B).
    assign trial = (TW'(root_in) << (B + 1)) | (TW'(1) << (2 * B));

    always_ff @(posedge clk_i) begin
      if (rem_in >= trial) begin
        rem_q[k]  <= rem_in - trial;
        root_q[k] <= root_in | (RW'(1) << B);
      end else begin
        rem_q[k]  <= rem_in;
        root_q[k] <= root_in;
      end
      side_q[k] <= side_in;
    end
  end

  assign valid_o = valid_q[RW-1];
  assign root_o  = root_q[RW-1];
  assign side_o  = side_q[RW-1];

endmodule

>>> src/tun_div.sv
module tun_div #(
  parameter int MW = 34,
  parameter int RW = 35,
  parameter int FRAC_BITS = 14,
  parameter int DW = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  logic [RW-1:0]     den_i,
  input  logic [MW-1:0]     num_i [tun_pkg::LANES],
  input  logic [DW-1:0]     side_i,
  output logic              valid_o,
  output logic [FRAC_BITS:0] quo_o [tun_pkg::LANES],
  output logic [DW-1:0]     side_o
);
  import tun_pkg::*;

  localparam int NS = FRAC_BITS + 1;
  localparam int AW = RW + 1;
  localparam int QW = FRAC_BITS + 1;

  logic [NS-1:0] valid_q;
  logic [AW-1:0] rem_q  [NS][LANES];
  logic [QW-1:0] quo_q  [NS][LANES];
  logic [RW-1:0] den_q  [NS];
  logic [DW-1:0] side_q [NS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[NS-2:0], valid_i};
    end
  end

  // Restoring division, one quotient bit per stage; the first stage gives the integer bit.
  for (genvar k = 0; k < NS; k++) begin : g_stage
    logic [AW-1:0] rem_in [LANES];
    logic [QW-1:0] quo_in [LANES];
    logic [RW-1:0] den_in;
    logic [DW-1:0] side_in;

    if (k == 0) begin : g_first
      for (genvar l = 0; l < LANES; l++) begin : g_lane
        assign rem_in[l] = AW'(num_i[l]);
        assign quo_in[l] = '0;
      end
      assign den_in  = den_i;
      assign side_in = side_i;
    end else begin : g_next
      for (genvar l = 0; l < LANES; l++) begin : g_lane
        assign rem_in[l] = rem_q[k-1][l] << 1;
        assign quo_in[l] = quo_q[k-1][l];
      end
      assign den_in  = den_q[k-1];
      assign side_in = side_q[k-1];
    end

    always_ff @(posedge clk_i) begin
      for (int l = 0; l < LANES; l++) begin
        if (rem_in[l] >= AW'(den_in)) begin
          rem_q[k][l] <= rem_in[l] - AW'(den_in);
          quo_q[k][l] <= {quo_in[l][QW-2:0], 1'b1};
        end else begin
          rem_q[k][l] <= rem_in[l];
          quo_q[k][l] <= {quo_in[l][QW-2:0], 1'b0};
        end
      end
      den_q[k]  <= den_in;
      side_q[k] <= side_in;
    end
  end

  assign valid_o = valid_q[NS-1];
  assign quo_o   = quo_q[NS-1];
  assign side_o  = side_q[NS-1];

endmodule

>>> tb/sv/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import tun_pkg::*;

  localparam int CW      = 16;
  localparam int FB      = 14;
  localparam int LATENCY = 2 * CW + FB + 11;

  typedef enum logic {MODE_POINTS = 1'b0, MODE_EDGES = 1'b1} mode_e;

  typedef struct packed {
    logic signed [OUT_W-1:0] nx;
    logic signed [OUT_W-1:0] ny;
    logic signed [OUT_W-1:0] nz;
    logic                    degenerate;
  } normal_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 start_i = 1'b0;
  logic                 busy_o;
  logic                 mode_i = 1'b0;
  logic signed [CW-1:0] ax_i = '0, ay_i = '0, az_i = '0;
  logic signed [CW-1:0] bx_i = '0, by_i = '0, bz_i = '0;
  logic signed [CW-1:0] cx_i = '0, cy_i = '0, cz_i = '0;
  logic                 valid_o;
  logic signed [OUT_W-1:0] nx_o, ny_o, nz_o;
  logic                 degenerate_o;

  normal_t normals_due[$];
  int      errors = 0;

  triangle_unit_normal DUT (
    .clk_i, .rst_ni, .start_i, .busy_o, .mode_i,
    .ax_i, .ay_i, .az_i, .bx_i, .by_i, .bz_i, .cx_i, .cy_i, .cz_i,
    .valid_o, .nx_o, .ny_o, .nz_o, .degenerate_o
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Floor square root of the sum of squares, one bit at a time.
  function automatic logic [63:0] root_of(logic [127:0] s);
    logic [63:0]  r;
    logic [63:0]  cand;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      cand = r | (64'd1 << b);
      if (128'(cand) * 128'(cand) <= s) r = cand;
    end
    return r;
  endfunction

  // Scaled component: truncated toward zero and clamped to one.
  function automatic logic [OUT_W-1:0] scale_comp(logic signed [63:0] c, logic [63:0] len);
    logic [127:0] q;
    logic [63:0]  mag;
    mag = c < 0 ? 64'(-c) : 64'(c);
    q = (128'(mag) << FB) / 128'(len);
    if (q > (128'd1 << FB)) q = 128'd1 << FB;
    if (c < 0) q = -q;
    return q[OUT_W-1:0];
  endfunction

  function automatic normal_t unit_normal(mode_e m, logic signed [CW-1:0] p[9]);
    logic signed [63:0]  e1[3], e2[3], n[3];
    logic [127:0]        sum;
    logic [63:0]         len;
    normal_t             r;
    for (int i = 0; i < 3; i++) begin
      if (m == MODE_EDGES) begin
        e1[i] = 64'(p[i]);
        e2[i] = 64'(p[3+i]);
      end else begin
        e1[i] = 64'(p[3+i]) - 64'(p[i]);
        e2[i] = 64'(p[6+i]) - 64'(p[i]);
      end
    end
    n[0] = e1[1] * e2[2] - e2[1] * e1[2];
    n[1] = e1[2] * e2[0] - e2[2] * e1[0];
    n[2] = e1[0] * e2[1] - e2[0] * e1[1];
    sum = '0;
    for (int i = 0; i < 3; i++) sum += 128'($signed(n[i])) * 128'($signed(n[i]));
    if (sum == 0) begin
      r = '{nx: '0, ny: '0, nz: '0, degenerate: 1'b1};
    end else begin
      len = root_of(sum);
      r = '{nx: scale_comp(n[0], len), ny: scale_comp(n[1], len),
            nz: scale_comp(n[2], len), degenerate: 1'b0};
    end
    return r;
  endfunction

  // Sends one word after a random gap and records its expected normal.
  task automatic send_triangle(mode_e m, logic signed [CW-1:0] p[9]);
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 13);
    if ($urandom_range(0, 5) == 0) gap = 0;
    repeat (gap) begin
      @(posedge clk_i);
      start_i <= 1'b0;
    end
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    start_i <= 1'b1;
    mode_i  <= m;
    {ax_i, ay_i, az_i, bx_i, by_i, bz_i, cx_i, cy_i, cz_i} <=
      {p[0], p[1], p[2], p[3], p[4], p[5], p[6], p[7], p[8]};
    normals_due.push_back(unit_normal(m, p));
  endtask

  task automatic drop_start();
    @(posedge clk_i);
    start_i <= 1'b0;
  endtask

  function automatic logic signed [CW-1:0] rand_coord(int range_sel);
    case (range_sel)
      0:       return CW'($urandom);
      1:       return CW'($signed($urandom_range(0, 16)) - 8);
      2:       return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      default: return CW'($signed($urandom_range(0, 400)) - 200);
    endcase
  endfunction

  task automatic test_extremes();
    logic signed [CW-1:0] p[9];
    logic signed [CW-1:0] lo, hi;
    lo = 16'sh8000;
    hi = 16'sh7fff;
    p = '{lo, lo, lo, hi, lo, lo, lo, hi, lo}; send_triangle(MODE_POINTS, p);
    p = '{hi, lo, hi, lo, hi, lo, hi, hi, lo}; send_triangle(MODE_EDGES, p);
    p = '{lo, lo, lo, lo, lo, lo, lo, lo, lo}; send_triangle(MODE_EDGES, p);
    p = '{hi, hi, lo, lo, lo, hi, hi, lo, hi}; send_triangle(MODE_POINTS, p);
    p = '{lo, hi, lo, hi, lo, hi, lo, lo, lo}; send_triangle(MODE_EDGES, p);
    drop_start();
  endtask

  task automatic test_degenerate();
    logic signed [CW-1:0] p[9];
    // Coincident points, collinear points and parallel edge vectors.
    p = '{16'sd5, 16'sd5, 16'sd5, 16'sd5, 16'sd5, 16'sd5, 16'sd5, 16'sd5, 16'sd5};
    send_triangle(MODE_POINTS, p);
    p = '{16'sd0, 16'sd0, 16'sd0, 16'sd1, 16'sd2, 16'sd3, 16'sd2, 16'sd4, 16'sd6};
    send_triangle(MODE_POINTS, p);
    p = '{16'sd3, -16'sd1, 16'sd2, -16'sd6, 16'sd2, -16'sd4, 16'sd9, 16'sd9, 16'sd9};
    send_triangle(MODE_EDGES, p);
    p = '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0};
    send_triangle(MODE_EDGES, p);
    drop_start();
  endtask

  task automatic test_axes();
    logic signed [CW-1:0] p[9];
    // Normals along each axis (the first edge-vector item has a noisy third point), then a general triangle.
    p = '{16'sd1, 16'sd0, 16'sd0, 16'sd0, 16'sd1, 16'sd0, -16'sd1, -16'sd1, 16'sh7fff};
    send_triangle(MODE_EDGES, p);
    p = '{16'sd0, 16'sd1, 16'sd0, 16'sd0, 16'sd0, 16'sd1, 16'sd0, 16'sd0, 16'sd0};
    send_triangle(MODE_EDGES, p);
    p = '{16'sd0, 16'sd0, 16'sd1, 16'sd1, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0};
    send_triangle(MODE_EDGES, p);
    p = '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd3, 16'sd0, 16'sd4, 16'sd0, 16'sd0};
    send_triangle(MODE_POINTS, p);
    p = '{16'sd1, 16'sd1, 16'sd1, 16'sd2, 16'sd3, 16'sd5, -16'sd7, 16'sd11, -16'sd13};
    send_triangle(MODE_POINTS, p);
    drop_start();
  endtask

  task automatic test_random(int count);
    logic signed [CW-1:0] p[9];
    int sel;
    repeat (count) begin
      sel = $urandom_range(0, 3);
      foreach (p[i]) p[i] = rand_coord($urandom_range(0, 7) == 0 ? $urandom_range(0, 3) : sel);
      // Now and then reuse a point so that degenerate triangles keep turning up.
      if ($urandom_range(0, 15) == 0) for (int i = 0; i < 3; i++) p[6+i] = p[3+i];
      send_triangle(mode_e'($urandom_range(0, 1)), p);
      if ($urandom_range(0, 4) == 0) drop_start();
    end
    drop_start();
  endtask

  // Compares each result word with the oldest expected normal.
  always @(posedge clk_i) begin
    normal_t got, want;
    if (rst_ni && valid_o) begin
      got = '{nx: nx_o, ny: ny_o, nz: nz_o, degenerate: degenerate_o};
      if (normals_due.size() == 0) begin
        $display("%0t: unexpected word %h", $time, got);
        errors++;
      end else begin
        want = normals_due.pop_front();
        if (got.nx !== want.nx) begin
          $display("%0t: nx expected %0d actual %0d", $time, want.nx, got.nx);
          errors++;
        end
        if (got.ny !== want.ny) begin
          $display("%0t: ny expected %0d actual %0d", $time, want.ny, got.ny);
          errors++;
        end
        if (got.nz !== want.nz) begin
          $display("%0t: nz expected %0d actual %0d", $time, want.nz, got.nz);
          errors++;
        end
        if (got.degenerate !== want.degenerate) begin
          $display("%0t: degenerate expected %b actual %b", $time, want.degenerate,
                   got.degenerate);
          errors++;
        end
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_extremes();
    test_degenerate();
    test_axes();
    test_random(750);
    while (normals_due.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  // Run guard, well above the slowest correct run.
  initial begin
    #2ms;
    $display("FAIL");
    $finish;
  end

endmodule

>>> files.f
src/tun_pkg.sv
src/tun_front.sv
src/tun_sqrt.sv
src/tun_div.sv
src/triangle_unit_normal.sv
tb/sv/tb_top.sv
